>>> src/vhf_pkg.sv
// Package for the ventilation hysteresis fan controller.
// Holds item and config types, field widths, codes and reset values.
// No dependencies.
package vhf_pkg;

    localparam int HUM_W      = 10;
    localparam int TEMP_W     = 12;
    localparam int HOUR_W     = 5;
    localparam int HUM_THR_W  = 7;
    localparam int TEMP_THR_W = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // hysteresis bands in tenths
    localparam int HUM_HYST_TENTHS  = 20;
    localparam int TEMP_HYST_TENTHS = 5;

    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_TIME = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_HUM_THR     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_THR_1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_THR_2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_HOUR  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FINISH_HOUR = 3'd4;

    localparam logic [1:0] SPEED_STOP = 2'd0;
    localparam logic [1:0] SPEED_SLOW = 2'd1;
    localparam logic [1:0] SPEED_FAST = 2'd2;

    localparam logic [1:0] LED_DARK   = 2'd0;
    localparam logic [1:0] LED_YELLOW = 2'd1;
    localparam logic [1:0] LED_GREEN  = 2'd2;
    localparam logic [1:0] LED_RED    = 2'd3;

    localparam logic [2:0] REASON_MOTION = 3'd0;
    localparam logic [2:0] REASON_HUM    = 3'd1;
    localparam logic [2:0] REASON_TEMP   = 3'd2;
    localparam logic [2:0] REASON_WORK   = 3'd3;
    localparam logic [2:0] REASON_OFF    = 3'd4;

    localparam logic        [HUM_THR_W-1:0]  HUM_THR_RST     = 7'd70;
    localparam logic signed [TEMP_THR_W-1:0] TEMP_THR_RST    = 8'sd25;
    localparam logic        [HOUR_W-1:0]     START_HOUR_RST  = 5'd7;
    localparam logic        [HOUR_W-1:0]     FINISH_HOUR_RST = 5'd22;

    typedef struct packed {
        logic                     action;
        logic                     motion_active;
        logic                     sensor_one_ok;
        logic        [HUM_W-1:0]  sensor_one_humidity;
        logic signed [TEMP_W-1:0] sensor_one_temp;
        logic                     sensor_two_ok;
        logic        [HUM_W-1:0]  sensor_two_humidity;
        logic signed [TEMP_W-1:0] sensor_two_temp;
        logic        [HOUR_W-1:0] hour_of_day;
    } t_in_item;

    typedef struct packed {
        logic [1:0] fan_speed;
        logic [1:0] led_color;
        logic [2:0] reason_code;
    } t_out_item;

    typedef struct packed {
        logic        [HUM_THR_W-1:0]  humidity_threshold;
        logic signed [TEMP_THR_W-1:0] temp_threshold_one;
        logic signed [TEMP_THR_W-1:0] temp_threshold_two;
        logic        [HOUR_W-1:0]     start_hour;
        logic        [HOUR_W-1:0]     finish_hour;
    } t_cfg;

    // status of the input stage toward the core and result register
    typedef struct packed {
        logic fire;  // held item is consumed this cycle
        logic tick;  // held item is an evaluation tick
    } t_s1_stat;

endpackage

>>> src/vhf_in_if.sv
// Input channel of the fan controller: valid/ready handshake plus item.
// Depends on vhf_pkg.
interface vhf_in_if import vhf_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/vhf_out_if.sv
// Result channel of the fan controller: valid/ready handshake plus item.
// Depends on vhf_pkg.
interface vhf_out_if import vhf_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/vhf_cfg_regs.sv
// Configuration register file: decodes the write port into thresholds and hours.
// Depends on vhf_pkg.
module vhf_cfg_regs import vhf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_we,
    input  logic [CFG_IDX_W-1:0]  i_idx,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_we) begin
            unique case (i_idx)
                CFG_HUM_THR:     n_cfg.humidity_threshold = i_data[HUM_THR_W-1:0];
                CFG_TEMP_THR_1:  n_cfg.temp_threshold_one = i_data[TEMP_THR_W-1:0];
                CFG_TEMP_THR_2:  n_cfg.temp_threshold_two = i_data[TEMP_THR_W-1:0];
                CFG_START_HOUR:  n_cfg.start_hour         = i_data[HOUR_W-1:0];
                CFG_FINISH_HOUR: n_cfg.finish_hour        = i_data[HOUR_W-1:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.humidity_threshold <= HUM_THR_RST;
            r_cfg.temp_threshold_one <= TEMP_THR_RST;
            r_cfg.temp_threshold_two <= TEMP_THR_RST;
            r_cfg.start_hour         <= START_HOUR_RST;
            r_cfg.finish_hour        <= FINISH_HOUR_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> src/vhf_in_reg.sv
// Input register stage: holds one item and decides when it moves on.
// Depends on vhf_pkg.
module vhf_in_reg import vhf_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_item i_data,
    output logic     o_ready,
    input  logic     i_out_free,
    output t_s1_stat o_stat,
    output t_in_item o_item
);

    logic     r_valid;
    t_in_item r_item;
    logic     s1_fire;
    logic     s1_tick;

    assign s1_tick = r_item.action == ACT_TICK;
    // a time update never needs the result register
    assign s1_fire = r_valid && (!s1_tick || i_out_free);
    assign o_ready = !r_valid || s1_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_data;
        end
    end

    assign o_stat.fire = s1_fire;
    assign o_stat.tick = s1_tick;
    assign o_item      = r_item;

endmodule

>>> src/vhf_core.sv
// Decision core: hysteresis flags, working-hours flag and priority mode select.
// Depends on vhf_pkg.
module vhf_core import vhf_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_s1_stat  i_stat,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_result
);

    logic r_hum_one, r_hum_two, r_temp_one, r_temp_two, r_work;
    logic n_hum_one, n_hum_two, n_temp_one, n_temp_two, n_work;

    // readings and thresholds in tenths, compared without going negative
    function automatic logic hum_hyst(input logic flag, input logic ok,
                                      input logic [HUM_W-1:0] value,
                                      input logic [HUM_THR_W-1:0] thr);
        logic [11:0] v;
        logic [11:0] c;
        logic [11:0] band;
        v    = 12'(value);
        c    = 12'(thr) * 12'd10;
        band = 12'(HUM_HYST_TENTHS);
        if (!ok) begin
            return 1'b0;
        end else if (flag) begin
            return !((v + band) < c);
        end else begin
            return v > (c + band);
        end
    endfunction

    function automatic logic temp_hyst(input logic flag, input logic ok,
                                       input logic signed [TEMP_W-1:0] value,
                                       input logic signed [TEMP_THR_W-1:0] thr);
        logic signed [13:0] v;
        logic signed [13:0] c;
        logic signed [13:0] band;
        v    = 14'(value);
        c    = 14'(thr) * 14'sd10;
        band = 14'(TEMP_HYST_TENTHS);
        if (!ok) begin
            return 1'b0;
        end else if (flag) begin
            return !(v < (c - band));
        end else begin
            return v > (c + band);
        end
    endfunction

    always_comb begin
        n_hum_one  = r_hum_one;
        n_hum_two  = r_hum_two;
        n_temp_one = r_temp_one;
        n_temp_two = r_temp_two;
        n_work     = r_work;
        if (i_stat.fire) begin
            if (i_stat.tick) begin
                // motion wins outright and leaves every flag alone
                if (!i_item.motion_active) begin
                    n_hum_one = hum_hyst(r_hum_one, i_item.sensor_one_ok,
                                         i_item.sensor_one_humidity,
                                         i_cfg.humidity_threshold);
                    n_hum_two = hum_hyst(r_hum_two, i_item.sensor_two_ok,
                                         i_item.sensor_two_humidity,
                                         i_cfg.humidity_threshold);
                    if (!(n_hum_one || n_hum_two)) begin
                        n_temp_one = temp_hyst(r_temp_one, i_item.sensor_one_ok,
                                               i_item.sensor_one_temp,
                                               i_cfg.temp_threshold_one);
                        n_temp_two = temp_hyst(r_temp_two, i_item.sensor_two_ok,
                                               i_item.sensor_two_temp,
                                               i_cfg.temp_threshold_two);
                    end
                end
            end else begin
                n_work = (i_cfg.start_hour <= i_item.hour_of_day) &&
                         (i_item.hour_of_day <= i_cfg.finish_hour);
            end
        end
    end

    always_comb begin
        if (i_item.motion_active) begin
            o_result = '{fan_speed: SPEED_FAST, led_color: LED_YELLOW,
                         reason_code: REASON_MOTION};
        end else if (n_hum_one || n_hum_two) begin
            o_result = '{fan_speed: SPEED_FAST, led_color: LED_GREEN,
                         reason_code: REASON_HUM};
        end else if (n_temp_one || n_temp_two) begin
            o_result = '{fan_speed: SPEED_FAST, led_color: LED_RED,
                         reason_code: REASON_TEMP};
        end else if (r_work) begin
            o_result = '{fan_speed: SPEED_SLOW, led_color: LED_DARK,
                         reason_code: REASON_WORK};
        end else begin
            o_result = '{fan_speed: SPEED_STOP, led_color: LED_DARK,
                         reason_code: REASON_OFF};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hum_one  <= 1'b0;
            r_hum_two  <= 1'b0;
            r_temp_one <= 1'b0;
            r_temp_two <= 1'b0;
            r_work     <= 1'b1;
        end else begin
            r_hum_one  <= n_hum_one;
            r_hum_two  <= n_hum_two;
            r_temp_one <= n_temp_one;
            r_temp_two <= n_temp_two;
            r_work     <= n_work;
        end
    end

endmodule

>>> src/vhf_out_reg.sv
// Result register: holds one result item until the sink takes it.
// Depends on vhf_pkg.
module vhf_out_reg import vhf_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_out_item i_result,
    input  logic      i_ready,
    output logic      o_free,
    output logic      o_valid,
    output t_out_item o_data
);

    logic      r_valid;
    t_out_item r_data;

    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_result;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> src/ventilation_hysteresis_fan_control.sv
// A tick's result passes the input register, then the result register; a time
// update is absorbed and gives no result. Throughput: one item per cycle, but
// a stalled result holds a tick in the input register.
// Reset (synchronous, active low) clears both stages, all high flags, sets the
// working-hours flag and loads the default thresholds and hours.
// Depends on vhf_pkg, vhf_in_if, vhf_out_if and the vhf_* submodules.
module ventilation_hysteresis_fan_control import vhf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    vhf_in_if.sink                i_in,
    vhf_out_if.source             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg      cfg;
    t_s1_stat  s1_stat;
    t_in_item  s1_item;
    t_out_item core_result;
    logic      out_free;

    vhf_cfg_regs u_cfg (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_we   (i_cfg_we),
        .i_idx  (i_cfg_idx),
        .i_data (i_cfg_data),
        .o_cfg  (cfg)
    );

    vhf_in_reg u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in.valid),
        .i_data    (i_in.data),
        .o_ready   (i_in.ready),
        .i_out_free(out_free),
        .o_stat    (s1_stat),
        .o_item    (s1_item)
    );

    vhf_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (s1_stat),
        .i_item  (s1_item),
        .i_cfg   (cfg),
        .o_result(core_result)
    );

    vhf_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (s1_stat.fire && s1_stat.tick),
        .i_result(core_result),
        .i_ready (o_out.ready),
        .o_free  (out_free),
        .o_valid (o_out.valid),
        .o_data  (o_out.data)
    );

endmodule

>>> src/vhf_checker.sv
// Port-level checks for the fan controller, bound to the top level.
// Depends on vhf_pkg and ventilation_hysteresis_fan_control.
module vhf_checker import vhf_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_item i_out_data
);

    // nothing is presented in the cycle after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled result changed or dropped");

    // fast fan exactly for the three demand modes
    a_fast_modes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_out_data.fan_speed == SPEED_FAST) ==
                         (i_out_data.reason_code == REASON_MOTION ||
                          i_out_data.reason_code == REASON_HUM ||
                          i_out_data.reason_code == REASON_TEMP)))
        else $error("fan speed does not match reason");

    a_idle_modes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_data.reason_code == REASON_WORK ||
                        i_out_data.reason_code == REASON_OFF)
        |-> i_out_data.led_color == LED_DARK)
        else $error("LED lit in an idle mode");

endmodule

bind ventilation_hysteresis_fan_control vhf_checker u_vhf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready),
    .i_out_data (o_out.data)
);
